/* design/five_bit_code_packer_macros.svh */
// assertion macros for the five-bit code packer
`ifndef FIVE_BIT_CODE_PACKER_MACROS_SVH
`define FIVE_BIT_CODE_PACKER_MACROS_SVH

// property that must hold at every clock edge out of reset
`define FBCP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// property of the form antecedent implies consequent on the next edge
`define FBCP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/fbcp_pkg.sv */
// shared types and constants for the five-bit code packer
package fbcp_pkg;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_LOAD = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	localparam logic [4:0] END_CODE   = 5'h1f;
	localparam int         FIFO_DEPTH = 8;
	localparam int         FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int         FIFO_CW    = $clog2(FIFO_DEPTH + 1);
	localparam int         TBL_DEPTH  = 256;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} res_t;

endpackage

/* design/five_bit_code_packer.sv */
// five-bit code packer: byte to code table lookup, msb-first packing, output queue
// path: an accepted item's table read and kind are registered into stage s1; from there the
//   packing step writes its results into the output queue, readable the cycle after
// throughput: one item per cycle; input stalls while more than four bytes wait in the queue
// reset: accumulator, bit count, queue and pipeline valid clear; the table holds no reset
`include "five_bit_code_packer_macros.svh"

module five_bit_code_packer import fbcp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [7:0] value,
	input  logic [4:0] code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last
);

	logic [4:0] code_table [TBL_DEPTH];
	logic [4:0] rd_s1;
	logic       v_s1;
	kind_t      kind_s1;

	logic [6:0] acc_q;
	logic [3:0] bc_q;
	logic [2:0] phase_q;

	res_t               fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q, rp_q;
	logic [FIFO_CW-1:0] cnt_q;

	logic        in_acc, pop;
	logic [4:0]  sym;
	logic [11:0] w;
	logic [3:0]  cnt;
	logic [3:0]  rr;
	logic [7:0]  top_byte, tail_byte;
	logic [19:0] tail_wide;
	logic [1:0]  n_push;
	res_t        push0, push1;
	logic [6:0]  acc_d;
	logic [3:0]  bc_d;
	logic [2:0]  phase_d;

	assign in_acc   = in_valid && in_ready;
	assign pop      = out_valid && out_ready;
	assign in_ready = (cnt_q <= FIFO_CW'(FIFO_DEPTH - 4));

	// table port: write on load, read on data
	always_ff @(posedge clk) begin
		if (in_acc && kind_t'(kind) == KIND_LOAD) begin
			code_table[value] <= code;
		end
		if (in_acc && kind_t'(kind) == KIND_DATA) begin
			rd_s1 <= code_table[value];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			kind_s1 <= KIND_NONE;
		end else begin
			v_s1    <= in_acc;
			kind_s1 <= kind_t'(kind);
		end
	end

	// packing step
	always_comb begin
		sym       = (kind_s1 == KIND_DATA) ? rd_s1 : END_CODE;
		w         = {acc_q, sym};
		cnt       = bc_q + 4'd5;
		top_byte  = 8'(w >> (cnt - 4'd8));
		rr        = (cnt > 4'd8) ? (cnt - 4'd8) : cnt;
		tail_wide = {8'b0, w} << (4'd8 - rr);
		tail_byte = tail_wide[7:0];
		n_push    = 2'd0;
		push0     = '{out_byte: top_byte, last: 1'b0};
		push1     = '{out_byte: tail_byte, last: 1'b1};
		acc_d     = acc_q;
		bc_d      = bc_q;
		phase_d   = phase_q;
		if (v_s1) begin
			case (kind_s1)
				KIND_DATA: begin
					phase_d = phase_q + 3'd1;
					if (cnt >= 4'd8) begin
						n_push = 2'd1;
						bc_d   = cnt - 4'd8;
					end else begin
						bc_d = cnt;
					end
					acc_d = 7'(w & ((12'd1 << bc_d) - 12'd1));
				end
				KIND_END: begin
					acc_d   = '0;
					bc_d    = '0;
					phase_d = '0;
					if (bc_q != 4'd0) begin
						if (cnt > 4'd8) begin
							n_push = 2'd2;
						end else begin
							n_push = 2'd1;
							push0  = push1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			bc_q    <= '0;
			phase_q <= '0;
			wp_q    <= '0;
			rp_q    <= '0;
			cnt_q   <= '0;
		end else begin
			acc_q   <= acc_d;
			bc_q    <= bc_d;
			phase_q <= phase_d;
			wp_q    <= wp_q + FIFO_AW'(n_push);
			rp_q    <= rp_q + FIFO_AW'(pop);
			cnt_q   <= cnt_q + FIFO_CW'(n_push) - FIFO_CW'(pop);
		end
	end

	// output queue storage
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			fifo_q[wp_q] <= push0;
		end
		if (n_push == 2'd2) begin
			fifo_q[wp_q + FIFO_AW'(1)] <= push1;
		end
	end

	assign out_valid = (cnt_q != '0);
	assign out_byte  = fifo_q[rp_q].out_byte;
	assign last      = fifo_q[rp_q].last;

	`FBCP_ASSERT(a_cnt_bound, cnt_q <= FIFO_CW'(FIFO_DEPTH), "output queue overflow")
	`FBCP_ASSERT(a_bc_bound, bc_q < 4'd8, "pending bit count out of range")
	`FBCP_ASSERT_NEXT(a_end_clears, v_s1 && kind_s1 == KIND_END,
		bc_q == 4'd0 && phase_q == 3'd0, "end of stream left pending bits")
	`FBCP_ASSERT_NEXT(a_data_phase, v_s1 && kind_s1 == KIND_DATA,
		phase_q == $past(phase_q) + 3'd1, "symbol phase did not advance")

endmodule
